>>> design/pbpg_pkg.sv
`default_nettype none
// Shared widths, operation codes, register indexes and reset values of the badge pixel generator.
package pbpg_pkg;

	localparam int OP_W       = 2;
	localparam int COORD_W    = 8;
	localparam int FRAME_W    = 16;
	localparam int COLOR_W    = 16;
	localparam int UNIT_W     = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [OP_W-1:0] OP_INFO  = 2'd0;
	localparam logic [OP_W-1:0] OP_WARN  = 2'd1;
	localparam logic [OP_W-1:0] OP_BANG  = 2'd2;
	localparam logic [OP_W-1:0] OP_PULSE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_UNIT_SIZE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACCENT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND = 2'd2;

	localparam logic [UNIT_W-1:0]  UNIT_SIZE_RST  = 4'd7;
	localparam logic [COLOR_W-1:0] ACCENT_RST     = 16'hFFFF;
	localparam logic [COLOR_W-1:0] BACKGROUND_RST = 16'h0000;

endpackage
`default_nettype wire

>>> design/procedural_badge_pixel_generator.sv
`default_nettype none
// Top level: five-stage pipelined pixel shader for the animated badge.
//
// Channel | Signals                                              | Direction
// in      | in_valid, in_ready, operation, pixel_x, pixel_y,     | into block
//         | frame_number                                         |
// out     | out_valid, out_ready, pixel_color                    | out of block
// cfg     | cfg_write, cfg_index, cfg_data                       | into block
//
// One word per cycle is taken and one result per cycle is delivered while out_ready stays high.
// The stages are geometry, squares and products, radius compares,
// color selection with channel scaling, and the output register.
// Each stage holds while the stage after it is full and stalled; bubbles collapse.
// Reset clears all valid bits and loads the register defaults.
module procedural_badge_pixel_generator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [pbpg_pkg::OP_W-1:0]        operation,
	input  wire  [pbpg_pkg::COORD_W-1:0]     pixel_x,
	input  wire  [pbpg_pkg::COORD_W-1:0]     pixel_y,
	input  wire  [pbpg_pkg::FRAME_W-1:0]     frame_number,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [pbpg_pkg::COLOR_W-1:0]     pixel_color,
	input  wire                              cfg_write,
	input  wire  [pbpg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire  [pbpg_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import pbpg_pkg::*;

	typedef logic [1:0] sel_t;
	localparam sel_t SEL_BG  = 2'd0;
	localparam sel_t SEL_ACC = 2'd1;
	localparam sel_t SEL_DIM = 2'd2;

	function automatic logic [5:0] div12(input logic [8:0] v);
		logic [18:0] p;
		p = 19'(v) * 19'd683;
		return p[18:13];
	endfunction

	// configuration registers
	logic [UNIT_W-1:0]  unit_size_q;
	logic [COLOR_W-1:0] accent_q;
	logic [COLOR_W-1:0] background_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_size_q  <= UNIT_SIZE_RST;
			accent_q     <= ACCENT_RST;
			background_q <= BACKGROUND_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_UNIT_SIZE:  unit_size_q  <= cfg_data[UNIT_W-1:0];
				REG_ACCENT:     accent_q     <= cfg_data;
				REG_BACKGROUND: background_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [3:0] u;
	logic [7:0] cen;
	logic [2:0] sw;
	logic [6:0] u7;
	logic [3:0] ug;

	assign u   = (unit_size_q == '0) ? 4'd1 : unit_size_q;
	assign cen = 8'(u) * 8'd12;
	assign sw  = (u[3:1] == 3'd0) ? 3'd1 : u[3:1];
	assign u7  = 7'(u) * 7'd7;
	assign ug  = (u7[6:3] == 4'd0) ? 4'd1 : u7[6:3];

	// pipeline control
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic en1, en2, en3, en4, en5;

	assign en5       = !vld_s5 || out_ready;
	assign en4       = !vld_s4 || en5;
	assign en3       = !vld_s3 || en4;
	assign en2       = !vld_s2 || en3;
	assign en1       = !vld_s1 || en2;
	assign in_ready  = en1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en4) vld_s4 <= vld_s3;
			if (en5) vld_s5 <= vld_s4;
		end
	end

	// stage 1: offsets from center and frame scaling
	logic [19:0]       fu;
	logic signed [9:0] dx, dy;

	assign fu = 20'(frame_number) * 20'(u);
	assign dx = $signed({2'b00, pixel_x}) - $signed({2'b00, cen});
	assign dy = $signed({2'b00, pixel_y}) - $signed({2'b00, cen});

	logic [OP_W-1:0]    op_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [2:0]         f_s1;
	logic [19:0]        fu_s1;
	logic signed [9:0]  dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= operation;
			x_s1  <= pixel_x;
			y_s1  <= pixel_y;
			f_s1  <= frame_number[2:0];
			fu_s1 <= fu;
			dx_s1 <= dx;
			dy_s1 <= dy;
		end
	end

	// stage 2: distance, radii, triangle products, glyph rectangles
	logic signed [19:0] dxx, dyy;
	logic [16:0]        dsq;
	logic [9:0]         dxn;
	logic [7:0]         adx;

	assign dxx = dx_s1 * dx_s1;
	assign dyy = dy_s1 * dy_s1;
	assign dsq = dxx[16:0] + dyy[16:0];
	assign dxn = dx_s1[9] ? 10'(-dx_s1) : dx_s1;
	assign adx = dxn[7:0];

	logic [5:0]  phu;
	logic [4:0]  ga;
	logic [18:0] halo;
	logic        halo_big;
	logic [2:0]  phk [3];

	assign phu      = 6'(f_s1[1:0]) * 6'(u);
	assign ga       = phu[5:1];
	assign halo     = 19'({u, 3'b000}) + 19'(fu_s1[19:1]);
	assign halo_big = |halo[18:9];

	logic [7:0] rd;
	logic [9:0] rin  [3];
	logic [9:0] rout [3];
	logic       ren  [3];
	logic [3:0] nn   [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			phk[k]  = f_s1 + 3'(3 * k);
			rin[k]  = '0;
			rout[k] = '0;
			ren[k]  = 1'b0;
			nn[k]   = '0;
		end
		rd = '0;
		unique case (op_s1)
			OP_INFO: begin
				rd      = 8'(u) * 8'd7;
				rin[0]  = 10'(halo[8:0]);
				rout[0] = 10'(halo[8:0]) + 10'(sw);
				ren[0]  = !halo_big;
				nn[0]   = 4'd7 - 4'(f_s1);
			end
			OP_WARN: begin
				nn[0] = 4'd8 - 4'({f_s1[1:0], 1'b0});
			end
			OP_BANG: begin
				rd      = 8'(u) * 8'd9;
				rin[0]  = 10'(u) * 10'd10 + 10'(ga);
				rout[0] = 10'(u) * 10'd10 + 10'(ga) + 10'(sw);
				ren[0]  = 1'b1;
				nn[0]   = 4'd8 - 4'({f_s1[1:0], 1'b0});
			end
			OP_PULSE: begin
				rd = 8'(u) * 8'd3;
				for (int k = 0; k < 3; k++) begin
					rin[k]  = 10'(u) * 10'd4 + 10'(phk[k]) * 10'(u);
					rout[k] = 10'(u) * 10'd4 + 10'(phk[k]) * 10'(u) + 10'(sw);
					ren[k]  = 1'b1;
					nn[k]   = 4'd8 - 4'(phk[k]);
				end
			end
			default: ;
		endcase
	end

	// triangle test as |dx| * span <= width * depth, for the shape, inner and outer outlines
	logic [5:0]  tg  [3];
	logic [9:0]  apx [3];
	logic [9:0]  bas [3];
	logic [9:0]  ydf [3];
	logic [7:0]  ht  [3];
	logic [8:0]  tdn [3];
	logic        tin [3];
	logic [16:0] tn  [3];
	logic [16:0] tm  [3];

	assign tg[0] = '0;
	assign tg[1] = 6'(ga);
	assign tg[2] = 6'(ga) + 6'(sw);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			apx[k] = 10'(u) * 10'd4 - 10'(tg[k]);
			bas[k] = 10'(u) * 10'd20 + 10'(tg[k]);
			tin[k] = (10'(y_s1) >= apx[k]) && (10'(y_s1) <= bas[k]);
			ydf[k] = 10'(y_s1) - apx[k];
			ht[k]  = 8'(u) * 8'd10 + 8'(tg[k]);
			tdn[k] = 9'(u) * 9'd16 + 9'({tg[k], 1'b0});
			tn[k]  = 17'(ht[k]) * 17'(ydf[k][8:0]);
			tm[k]  = 17'(adx) * 17'(tdn[k]);
		end
	end

	logic [3:0] gu;
	logic [7:0] u11;
	logic [9:0] gtop, gxl, gxh, gy1, gy2, gy3, gxv, gyv;
	logic       glyph;

	assign gu  = (op_s1 == OP_WARN) ? ug : u;
	assign u11 = 8'(u) * 8'd11;
	assign gxv = 10'(x_s1);
	assign gyv = 10'(y_s1);

	always_comb begin
		if (op_s1 == OP_WARN) begin
			gtop = 10'(cen) + 10'(u) * 10'd6 - 10'(ug) * 10'd11;
		end else begin
			gtop = 10'(cen) - 10'(u11[7:1]);
		end
		gxl = 10'(cen) - 10'(gu);
		gxh = 10'(cen) + 10'(gu);
		if (op_s1 == OP_INFO) begin
			gy1 = gtop + 10'(gu) * 10'd2;
			gy2 = gtop + 10'(gu) * 10'd4;
		end else begin
			gy1 = gtop + 10'(gu) * 10'd7;
			gy2 = gtop + 10'(gu) * 10'd9;
		end
		gy3   = gtop + 10'(gu) * 10'd11;
		glyph = (op_s1 != OP_PULSE) && (gxv >= gxl) && (gxv < gxh) &&
			(((gyv >= gtop) && (gyv < gy1)) || ((gyv >= gy2) && (gyv < gy3)));
	end

	logic [OP_W-1:0] op_s2;
	logic [16:0]     d_s2;
	logic [7:0]      rd_s2;
	logic [9:0]      rin_s2  [3];
	logic [9:0]      rout_s2 [3];
	logic            ren_s2  [3];
	logic [3:0]      n_s2    [3];
	logic            tin_s2  [3];
	logic [16:0]     tn_s2   [3];
	logic [16:0]     tm_s2   [3];
	logic            glyph_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2    <= op_s1;
			d_s2     <= dsq;
			rd_s2    <= rd;
			glyph_s2 <= glyph;
			for (int k = 0; k < 3; k++) begin
				rin_s2[k]  <= rin[k];
				rout_s2[k] <= rout[k];
				ren_s2[k]  <= ren[k];
				n_s2[k]    <= nn[k];
				tin_s2[k]  <= tin[k];
				tn_s2[k]   <= tn[k];
				tm_s2[k]   <= tm[k];
			end
		end
	end

	// stage 3: radius squares and hit tests
	logic [15:0] rdsq;
	logic [19:0] rinsq  [3];
	logic [19:0] routsq [3];
	logic        rhit   [3];
	logic        thit   [3];
	logic        shape;
	logic        ring   [3];

	assign rdsq = 16'(rd_s2) * 16'(rd_s2);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rinsq[k]  = 20'(rin_s2[k]) * 20'(rin_s2[k]);
			routsq[k] = 20'(rout_s2[k]) * 20'(rout_s2[k]);
			rhit[k]   = ren_s2[k] && (20'(d_s2) >= rinsq[k]) && (20'(d_s2) <= routsq[k]);
			thit[k]   = tin_s2[k] && (tn_s2[k] >= tm_s2[k]);
		end
		if (op_s2 == OP_WARN) begin
			shape   = thit[0];
			ring[0] = thit[2] && !thit[1];
		end else begin
			shape   = 17'(rdsq) >= d_s2;
			ring[0] = rhit[0];
		end
		ring[1] = rhit[1];
		ring[2] = rhit[2];
	end

	logic       shape_s3, glyph_s3;
	logic       ring_s3 [3];
	logic [3:0] n_s3    [3];

	always_ff @(posedge clk) begin
		if (en3) begin
			shape_s3 <= shape;
			glyph_s3 <= glyph_s2;
			for (int k = 0; k < 3; k++) begin
				ring_s3[k] <= ring[k];
				n_s3[k]    <= n_s2[k];
			end
		end
	end

	// stage 4: pick the color source and scale the accent channels
	sel_t       sel;
	logic [3:0] nsel;
	logic [8:0] pr, pg, pb;

	always_comb begin
		sel  = SEL_BG;
		nsel = '0;
		if (shape_s3) begin
			sel = glyph_s3 ? SEL_BG : SEL_ACC;
		end else if (ring_s3[0]) begin
			sel  = SEL_DIM;
			nsel = n_s3[0];
		end else if (ring_s3[1]) begin
			sel  = SEL_DIM;
			nsel = n_s3[1];
		end else if (ring_s3[2]) begin
			sel  = SEL_DIM;
			nsel = n_s3[2];
		end
	end

	assign pr = 9'(accent_q[15:11]) * 9'(nsel);
	assign pg = 9'(accent_q[10:5]) * 9'(nsel);
	assign pb = 9'(accent_q[4:0]) * 9'(nsel);

	sel_t       sel_s4;
	logic [8:0] pr_s4, pg_s4, pb_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			sel_s4 <= sel;
			pr_s4  <= pr;
			pg_s4  <= pg;
			pb_s4  <= pb;
		end
	end

	// stage 5: divide by twelve, pack and register the word
	logic [5:0]         qr, qg, qb;
	logic [COLOR_W-1:0] col;

	assign qr = div12(pr_s4);
	assign qg = div12(pg_s4);
	assign qb = div12(pb_s4);

	always_comb begin
		case (sel_s4)
			SEL_ACC: col = accent_q;
			SEL_DIM: col = {qr[4:0], qg[5:0], qb[4:0]};
			default: col = background_q;
		endcase
	end

	logic [COLOR_W-1:0] pixel_color_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			pixel_color_s5 <= col;
		end
	end

	assign pixel_color = pixel_color_s5;

endmodule
`default_nettype wire

>>> design/pbpg_checker.sv
`default_nettype none
// Port-level checker for the badge pixel generator, bound to the top level.
module pbpg_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              in_valid,
	input wire                              in_ready,
	input wire  [pbpg_pkg::OP_W-1:0]        operation,
	input wire  [pbpg_pkg::COORD_W-1:0]     pixel_x,
	input wire  [pbpg_pkg::COORD_W-1:0]     pixel_y,
	input wire  [pbpg_pkg::FRAME_W-1:0]     frame_number,
	input wire                              out_valid,
	input wire                              out_ready,
	input wire  [pbpg_pkg::COLOR_W-1:0]     pixel_color
);
	import pbpg_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(operation) && $stable(pixel_x) &&
			$stable(pixel_y) && $stable(frame_number))
		else $error("input word dropped or changed before acceptance");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color))
		else $error("stalled output word changed");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid || out_ready |-> in_ready)
		else $error("input blocked while output side drains");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready
		|=> out_valid)
		else $error("word did not reach output after five free cycles");

endmodule

bind procedural_badge_pixel_generator pbpg_checker u_pbpg_checker (.*);
`default_nettype wire

>>> verif/pbpg_color_checker.sv
`timescale 1ns / 100ps
// Channel monitor, pixel color predictor and in-order comparison for the badge pixel generator.
module pbpg_color_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [pbpg_pkg::OP_W-1:0]       operation,
	input  logic [pbpg_pkg::COORD_W-1:0]    pixel_x,
	input  logic [pbpg_pkg::COORD_W-1:0]    pixel_y,
	input  logic [pbpg_pkg::FRAME_W-1:0]    frame_number,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [pbpg_pkg::COLOR_W-1:0]    pixel_color,
	input  logic                            cfg_write,
	input  logic [pbpg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pbpg_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              mismatches,
	output int                              pending
);
	import pbpg_pkg::*;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [FRAME_W-1:0] frame;
		logic [COLOR_W-1:0] color;
	} pixel_due_t;

	logic [UNIT_W-1:0]  unit_q;
	logic [COLOR_W-1:0] accent_q;
	logic [COLOR_W-1:0] backgr_q;
	pixel_due_t         color_due_q[$];
	pixel_due_t         seen;
	pixel_due_t         fresh;

	function automatic logic [COLOR_W-1:0] scaled_color(logic [COLOR_W-1:0] c, longint num);
		longint r;
		longint g;
		longint b;
		if (num <= 0) return '0;
		r = longint'(c[15:11]);
		g = longint'(c[10:5]);
		b = longint'(c[4:0]);
		r = r * num / 12;
		g = g * num / 12;
		b = b * num / 12;
		return {r[4:0], g[5:0], b[4:0]};
	endfunction

	function automatic bit in_disc(longint dx, longint dy, longint r);
		return dx * dx + dy * dy <= r * r;
	endfunction

	function automatic bit in_ring(longint dx, longint dy, longint rin, longint rout);
		longint d;
		d = dx * dx + dy * dy;
		return d >= rin * rin && d <= rout * rout;
	endfunction

	function automatic bit in_rect(longint x, longint y, longint rx, longint ry,
			longint rw, longint rh);
		return x >= rx && x < rx + rw && y >= ry && y < ry + rh;
	endfunction

	function automatic bit bang_mark(longint x, longint y, longint cx, longint top, longint u);
		return in_rect(x, y, cx - u, top, 2 * u, 7 * u) ||
			in_rect(x, y, cx - u, top + 9 * u, 2 * u, 2 * u);
	endfunction

	function automatic bit info_mark(longint x, longint y, longint cx, longint top, longint u);
		return in_rect(x, y, cx - u, top, 2 * u, 2 * u) ||
			in_rect(x, y, cx - u, top + 4 * u, 2 * u, 7 * u);
	endfunction

	function automatic bit in_triangle(longint x, longint y, longint c, longint u, longint g);
		longint apex;
		longint base;
		longint half;
		apex = c - 8 * u - g;
		base = c + 8 * u + g;
		if (y < apex || y > base) return 1'b0;
		half = (10 * u + g) * (y - apex) / (base - apex);
		return x >= c - half && x <= c + half;
	endfunction

	function automatic logic [COLOR_W-1:0] badge_color(logic [OP_W-1:0] op,
			logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [FRAME_W-1:0] frm);
		longint u;
		longint x;
		longint y;
		longint fr;
		longint c;
		longint dx;
		longint dy;
		longint sw;
		longint halo;
		longint ph;
		longint g;
		longint r;
		longint ug;
		longint k;
		logic [COLOR_W-1:0] col;
		bit hit;
		u = longint'(unit_q);
		if (u == 0) u = 1;
		x = longint'(px);
		y = longint'(py);
		fr = longint'(frm);
		c = 12 * u;
		dx = x - c;
		dy = y - c;
		sw = (u / 2 > 0) ? u / 2 : 1;
		col = backgr_q;
		case (op)
			OP_INFO: begin
				halo = 8 * u + fr * u / 2;
				if (in_disc(dx, dy, 7 * u))
					col = info_mark(x, y, c, c - 11 * u / 2, u) ? backgr_q : accent_q;
				else if (in_ring(dx, dy, halo, halo + sw))
					col = scaled_color(accent_q, 7 - fr % 8);
			end
			OP_WARN: begin
				if (in_triangle(x, y, c, u, 0)) begin
					ug = (u * 7) / 8 > 0 ? (u * 7) / 8 : 1;
					col = bang_mark(x, y, c, c + 6 * u - 11 * ug, ug) ? backgr_q : accent_q;
				end else begin
					ph = fr % 4;
					g = ph * u / 2;
					if (in_triangle(x, y, c, u, g + sw) && !in_triangle(x, y, c, u, g))
						col = scaled_color(accent_q, 8 - ph * 2);
				end
			end
			OP_BANG: begin
				ph = fr % 4;
				r = 10 * u + ph * u / 2;
				if (in_disc(dx, dy, 9 * u))
					col = bang_mark(x, y, c, c - 11 * u / 2, u) ? backgr_q : accent_q;
				else if (in_ring(dx, dy, r, r + sw))
					col = scaled_color(accent_q, 8 - ph * 2);
			end
			default: begin
				if (in_disc(dx, dy, 3 * u)) begin
					col = accent_q;
				end else begin
					hit = 1'b0;
					for (k = 0; k < 3; k++) begin
						if (!hit) begin
							ph = (fr + k * 3) % 8;
							r = 4 * u + ph * u;
							if (in_ring(dx, dy, r, r + sw)) begin
								col = scaled_color(accent_q, 8 - ph);
								hit = 1'b1;
							end
						end
					end
				end
			end
		endcase
		return col;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q = UNIT_SIZE_RST;
			accent_q = ACCENT_RST;
			backgr_q = BACKGROUND_RST;
			color_due_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (color_due_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel_color %h delivered with no pixel outstanding",
							pixel_color);
				end else begin
					seen = color_due_q.pop_front();
					if (seen.color !== pixel_color) begin
						mismatches++;
						if (mismatches <= 10)
							$display("pixel_color mismatch: op %0d x %0d y %0d frame %0d expected %h got %h",
								seen.op, seen.x, seen.y, seen.frame, seen.color, pixel_color);
					end
				end
			end
			if (in_valid && in_ready) begin
				fresh.op = operation;
				fresh.x = pixel_x;
				fresh.y = pixel_y;
				fresh.frame = frame_number;
				fresh.color = badge_color(operation, pixel_x, pixel_y, frame_number);
				color_due_q.push_back(fresh);
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_UNIT_SIZE:  unit_q = cfg_data[UNIT_W-1:0];
					REG_ACCENT:     accent_q = cfg_data[COLOR_W-1:0];
					REG_BACKGROUND: backgr_q = cfg_data[COLOR_W-1:0];
					default: ;
				endcase
			end
			pending = color_due_q.size();
		end
	end

endmodule

>>> verif/procedural_badge_pixel_generator_tb.sv
`timescale 1ns / 100ps
// Stimulus, flow control and verdict for the badge pixel generator testbench.
module procedural_badge_pixel_generator_tb;
	import pbpg_pkg::*;

	localparam int PICK_RANDOM     = -1;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 92;
	localparam int DRAIN_CYCLES    = 10;
	localparam int WATCHDOG_LIMIT  = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [OP_W-1:0]       operation;
	logic [COORD_W-1:0]    pixel_x;
	logic [COORD_W-1:0]    pixel_y;
	logic [FRAME_W-1:0]    frame_number;
	logic                  out_valid;
	logic                  out_ready;
	logic [COLOR_W-1:0]    pixel_color;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;

	int idle_pct;
	int stall_pct;
	int unit_now;
	int quiet_cycles;

	int unit_plan[PHASES]   = '{1, 10, 0, 15, 7, 4, PICK_RANDOM, 2};
	int accent_plan[PHASES] = '{16'hFFFF, 16'hF800, PICK_RANDOM, 0, PICK_RANDOM, 16'h07E0,
		PICK_RANDOM, 16'hFFFF};
	int backgr_plan[PHASES] = '{0, 16'h001F, PICK_RANDOM, 16'hFFFF, PICK_RANDOM, 16'hFFFF,
		PICK_RANDOM, 0};
	int idle_plan[PHASES]   = '{0, 73, 0, 14, 0, 73, 0, 14};
	int stall_plan[PHASES]  = '{0, 0, 73, 14, 0, 0, 73, 14};

	procedural_badge_pixel_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	pbpg_color_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.frame_number (frame_number),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_color  (pixel_color),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	function automatic int root_ceil(int v);
		int s;
		s = 0;
		while (s * s < v) s++;
		return s;
	endfunction

	function automatic logic [COORD_W-1:0] to_coord(int v);
		if (v < 0) return '0;
		if (v > 255) return 8'd255;
		return v[COORD_W-1:0];
	endfunction

	// leaves valid high after the accepting edge; the caller drops it via settle
	task automatic send_pixel(logic [OP_W-1:0] op, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [FRAME_W-1:0] fr);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		pixel_x      <= x;
		pixel_y      <= y;
		frame_number <= fr;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_random_pixel();
		int u;
		int c;
		int span;
		int r;
		int dx;
		int dy;
		int sel;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [FRAME_W-1:0] fr;
		logic [OP_W-1:0]    op;
		u = (unit_now == 0) ? 1 : unit_now;
		c = 12 * u;
		span = (24 * u > 256) ? 256 : 24 * u;
		sel = $urandom_range(0, 9);
		if (sel < 2) begin
			x = COORD_W'($urandom_range(0, 255));
			y = COORD_W'($urandom_range(0, 255));
		end else if (sel < 5) begin
			// land near a circle around the center so thin rings get hit
			r = $urandom_range(3 * u, 14 * u);
			dx = $urandom_range(0, r);
			dy = root_ceil(r * r - dx * dx);
			if ($urandom_range(0, 1)) dx = -dx;
			if ($urandom_range(0, 1)) dy = -dy;
			if ($urandom_range(0, 1)) begin
				x = to_coord(c + dx);
				y = to_coord(c + dy);
			end else begin
				x = to_coord(c + dy);
				y = to_coord(c + dx);
			end
		end else begin
			x = COORD_W'($urandom_range(0, span - 1));
			y = COORD_W'($urandom_range(0, span - 1));
		end
		fr = ($urandom_range(0, 3) == 0) ? FRAME_W'($urandom) : FRAME_W'($urandom_range(0, 15));
		op = OP_W'($urandom_range(0, 3));
		send_pixel(op, x, y, fr);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic int plan_value(int planned, int hi);
		return (planned == PICK_RANDOM) ? $urandom_range(0, hi) : planned;
	endfunction

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_INFO;
		pixel_x      = '0;
		pixel_y      = '0;
		frame_number = '0;
		cfg_write    = 1'b0;
		cfg_index    = REG_UNIT_SIZE;
		cfg_data     = '0;
		idle_pct     = 0;
		stall_pct    = 0;
		unit_now     = UNIT_SIZE_RST;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		settle();
		write_reg(REG_ACCENT, 16'hFFFF);
		write_reg(REG_BACKGROUND, 16'h18E3);
		end_writes();

		send_pixel(OP_INFO, 8'd84, 8'd84, 16'd0);
		send_pixel(OP_INFO, 8'd70, 8'd84, 16'd0);
		send_pixel(OP_INFO, 8'd141, 8'd84, 16'd0);
		send_pixel(OP_INFO, 8'd165, 8'd84, 16'd7);
		send_pixel(OP_WARN, 8'd84, 8'd84, 16'd0);
		send_pixel(OP_WARN, 8'd84, 8'd110, 16'd1);
		send_pixel(OP_WARN, 8'd84, 8'd142, 16'd0);
		send_pixel(OP_WARN, 8'd84, 8'd149, 16'd2);
		send_pixel(OP_BANG, 8'd84, 8'd84, 16'd0);
		send_pixel(OP_BANG, 8'd60, 8'd84, 16'd0);
		send_pixel(OP_BANG, 8'd165, 8'd84, 16'd3);
		send_pixel(OP_PULSE, 8'd84, 8'd84, 16'd0);
		send_pixel(OP_PULSE, 8'd113, 8'd84, 16'd0);
		send_pixel(OP_PULSE, 8'd162, 8'd84, 16'd7);
		send_pixel(OP_INFO, 8'd0, 8'd0, 16'd0);
		send_pixel(OP_WARN, 8'd0, 8'd0, 16'd0);
		send_pixel(OP_BANG, 8'd0, 8'd0, 16'd0);
		send_pixel(OP_PULSE, 8'd0, 8'd0, 16'd0);
		send_pixel(OP_INFO, 8'd255, 8'd255, 16'hFFFF);
		send_pixel(OP_WARN, 8'd255, 8'd255, 16'hFFFF);
		send_pixel(OP_BANG, 8'd255, 8'd255, 16'hFFFF);
		send_pixel(OP_PULSE, 8'd255, 8'd255, 16'hFFFF);
		send_pixel(OP_INFO, 8'd250, 8'd3, 16'd12345);

		for (int p = 0; p < PHASES; p++) begin
			settle();
			unit_now = plan_value(unit_plan[p], 15);
			write_reg(REG_UNIT_SIZE, CFG_DATA_W'(unit_now));
			write_reg(REG_ACCENT, CFG_DATA_W'(plan_value(accent_plan[p], 16'hFFFF)));
			write_reg(REG_BACKGROUND, CFG_DATA_W'(plan_value(backgr_plan[p], 16'hFFFF)));
			end_writes();
			idle_pct  = idle_plan[p];
			stall_pct = stall_plan[p];
			repeat (ITEMS_PER_PHASE) send_random_pixel();
		end

		settle();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
